// File: rtl/core/strmq_pkg.sv
// strmq_pkg: shared types and constants of the sparse-table range-minimum core
// depends on nothing; used by strmq_store and sparse_table_range_minimum_core
`default_nettype none

package strmq_pkg;

    // fixed field widths of the stream items
    localparam int MODE_W       = 2;
    localparam int ELEM_INDEX_W = 10;
    localparam int VALUE_BITS   = 32;
    localparam int POS_OUT_W    = 10;
    localparam int LEN_CFG_W    = 11;

    // default storage sizes
    localparam int DEF_MAX_ELEMENTS = 1024;
    localparam int DEF_TABLE_LEVELS = 11;

    // input tdata layout, lowest bit first
    localparam int S_IDX_LSB   = 0;
    localparam int S_VAL_LSB   = S_IDX_LSB + ELEM_INDEX_W;
    localparam int S_LEFT_LSB  = S_VAL_LSB + VALUE_BITS;
    localparam int S_RIGHT_LSB = S_LEFT_LSB + ELEM_INDEX_W;
    localparam int S_TDATA_W   = ((S_RIGHT_LSB + ELEM_INDEX_W + 7) / 8) * 8;
    localparam int S_TUSER_W   = MODE_W;

    // output tdata layout, lowest bit first
    localparam int M_VAL_LSB = 0;
    localparam int M_POS_LSB = M_VAL_LSB + VALUE_BITS;
    localparam int M_TDATA_W = ((M_POS_LSB + POS_OUT_W + 7) / 8) * 8;
    localparam int M_TUSER_W = 1;

    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE = 2'd0,
        MODE_BUILD = 2'd1,
        MODE_QUERY = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_B_TAB,
        ST_B_VAL,
        ST_B_CMP,
        ST_Q_TAB,
        ST_Q_VAL,
        ST_Q_OUT
    } state_t;

    // memory strobes from the sequencer to the storage
    typedef struct packed {
        logic elem_we;
        logic elem_re;
        logic tab_we;
        logic tab_re;
    } mem_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/strmq_store.sv
// strmq_store: element store and argmin table memories, two registered read ports each
// depends on strmq_pkg
`default_nettype none

module strmq_store #(
    parameter int MAX_ELEMENTS = strmq_pkg::DEF_MAX_ELEMENTS,
    parameter int TABLE_LEVELS = strmq_pkg::DEF_TABLE_LEVELS,
    localparam int IDX_W       = $clog2(MAX_ELEMENTS),
    localparam int LVL_W       = $clog2(TABLE_LEVELS)
) (
    input  wire logic                                aclk,
    input  wire strmq_pkg::mem_ctl_t                 ctl,
    input  wire logic [IDX_W-1:0]                    elem_waddr,
    input  wire logic [strmq_pkg::VALUE_BITS-1:0]    elem_wdata,
    input  wire logic [IDX_W-1:0]                    elem_raddr_a,
    input  wire logic [IDX_W-1:0]                    elem_raddr_b,
    output logic [strmq_pkg::VALUE_BITS-1:0]         elem_rdata_a,
    output logic [strmq_pkg::VALUE_BITS-1:0]         elem_rdata_b,
    input  wire logic [LVL_W-1:0]                    tab_wlvl,
    input  wire logic [IDX_W-1:0]                    tab_wrow,
    input  wire logic [IDX_W-1:0]                    tab_wdata,
    input  wire logic [LVL_W-1:0]                    tab_rlvl,
    input  wire logic [IDX_W-1:0]                    tab_rrow_a,
    input  wire logic [IDX_W-1:0]                    tab_rrow_b,
    output logic [IDX_W-1:0]                         tab_rdata_a,
    output logic [IDX_W-1:0]                         tab_rdata_b
);

    // level 0 is the identity and is not stored; entry n holds level n+1
    localparam int TAB_DEPTH = (TABLE_LEVELS - 1) * (2 ** IDX_W);
    localparam int TADDR_W   = $clog2(TAB_DEPTH);

    logic [strmq_pkg::VALUE_BITS-1:0] elem_mem [MAX_ELEMENTS];
    logic [IDX_W-1:0]                 tab_mem  [TAB_DEPTH];

    logic [TADDR_W-1:0] tab_waddr;
    logic [TADDR_W-1:0] tab_raddr_a;
    logic [TADDR_W-1:0] tab_raddr_b;

    assign tab_waddr   = TADDR_W'({tab_wlvl, tab_wrow});
    assign tab_raddr_a = TADDR_W'({tab_rlvl, tab_rrow_a});
    assign tab_raddr_b = TADDR_W'({tab_rlvl, tab_rrow_b});

    always_ff @(posedge aclk) begin
        if (ctl.elem_we) begin
            elem_mem[elem_waddr] <= elem_wdata;
        end
        if (ctl.elem_re) begin
            elem_rdata_a <= elem_mem[elem_raddr_a];
            elem_rdata_b <= elem_mem[elem_raddr_b];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.tab_we) begin
            tab_mem[tab_waddr] <= tab_wdata;
        end
        if (ctl.tab_re) begin
            tab_rdata_a <= tab_mem[tab_raddr_a];
            tab_rdata_b <= tab_mem[tab_raddr_b];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/sparse_table_range_minimum_core.sv
// sparse_table_range_minimum_core: range-minimum queries over a sparse table of argmin positions
// depends on strmq_pkg and strmq_store
`default_nettype none

// The core holds up to MAX_ELEMENTS signed values and a sparse table of argmin positions
// with TABLE_LEVELS levels. An input item's mode (tuser) picks the job: write one element,
// build the table over the first array_length elements, or query an inclusive range.
// Only a query gives a result item: the minimum value and its position, or range_error
// with zero value and position when the range is reversed or reaches past array_length.
// A build keeps the later position on equal values, a query the first block. The core
// takes one item at a time and drops s_tready until that item is done. A write is done on
// acceptance; a query runs table read, element read and compare, and an out-of-range
// query goes straight to the compare step. A build does one table read, one element read
// pair and one compare in the shared comparator per table entry, for n elements over
// L = min(floor(log2 n) + 1, TABLE_LEVELS) levels. The result sits in an output register,
// so the core takes new items while it waits on m_tready; a further query holds in its
// compare step until the register frees. Memories start undefined and are not cleared;
// elements must be written before a build reads them. Level 0 of the table is the
// identity and is not stored. array_length may only be written while the core is idle.

module sparse_table_range_minimum_core #(
    parameter int MAX_ELEMENTS = strmq_pkg::DEF_MAX_ELEMENTS,
    parameter int TABLE_LEVELS = strmq_pkg::DEF_TABLE_LEVELS
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration: array_length
    input  wire logic                              cfg_wr_en,
    input  wire logic [strmq_pkg::LEN_CFG_W-1:0]   cfg_wr_data,
    // input items
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // element_index, element_value, left_index, right_index, zero pad
    input  wire logic [strmq_pkg::S_TDATA_W-1:0]   s_tdata,
    // mode
    input  wire logic [strmq_pkg::S_TUSER_W-1:0]   s_tuser,
    // result items
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // min_value, min_position, zero pad
    output logic [strmq_pkg::M_TDATA_W-1:0]        m_tdata,
    // range_error
    output logic [strmq_pkg::M_TUSER_W-1:0]        m_tuser
);

    localparam int IDX_W  = $clog2(MAX_ELEMENTS);
    localparam int LVL_W  = $clog2(TABLE_LEVELS);
    localparam int CLOG_N = $clog2(MAX_ELEMENTS + 1);
    localparam int LEN_W  = (CLOG_N > strmq_pkg::LEN_CFG_W) ? CLOG_N : strmq_pkg::LEN_CFG_W;
    localparam int SPAN_W = ((LEN_W > TABLE_LEVELS) ? LEN_W : TABLE_LEVELS) + 1;
    localparam int KRAW_W = $clog2(strmq_pkg::LEN_CFG_W);
    localparam int EIW    = strmq_pkg::ELEM_INDEX_W;
    localparam int VW     = strmq_pkg::VALUE_BITS;
    localparam int CW     = strmq_pkg::LEN_CFG_W;

    // sequencer and control registers
    strmq_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]      array_length_reg;
    logic               m_tvalid_reg, m_tvalid_next;

    // loop counters and item payload
    logic [LVL_W-1:0]   lvl_reg, lvl_next;
    logic [IDX_W-1:0]   row_reg, row_next;
    logic [EIW-1:0]     l_reg, l_next;
    logic [EIW-1:0]     r_reg, r_next;
    logic [CW-1:0]      len_reg, len_next;
    logic               err_reg, err_next;
    logic [LVL_W-1:0]   k_reg, k_next;
    logic [EIW-1:0]     start2_reg, start2_next;
    logic [IDX_W-1:0]   pos_a_reg, pos_a_next;
    logic [IDX_W-1:0]   pos_b_reg, pos_b_next;
    logic [strmq_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [strmq_pkg::M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;

    // memory side
    strmq_pkg::mem_ctl_t ctl;
    logic [IDX_W-1:0]   elem_waddr, elem_raddr_a, elem_raddr_b;
    logic [VW-1:0]      elem_rdata_a, elem_rdata_b;
    logic [LVL_W-1:0]   tab_wlvl, tab_rlvl;
    logic [IDX_W-1:0]   tab_wrow, tab_wdata, tab_rrow_a, tab_rrow_b;
    logic [IDX_W-1:0]   tab_rdata_a, tab_rdata_b;

    // input item fields
    logic               in_accept;
    strmq_pkg::mode_t   in_mode;
    logic [EIW-1:0]     in_index, in_left, in_right;
    logic [VW-1:0]      in_value;

    // derived values
    logic [LEN_W-1:0]   eff_len;
    logic               idx_in_range;
    logic               q_err;
    logic [SPAN_W-1:0]  span, half, row_p1;
    logic [IDX_W-1:0]   row_half;
    logic [KRAW_W-1:0]  k_raw;
    logic [LVL_W-1:0]   q_k;
    logic [CW-1:0]      q_pow;
    logic [EIW-1:0]     q_start2;

    // shared comparator
    logic               cmp_lt, cmp_eq, tie_first, pick_a;
    logic [IDX_W-1:0]   pick_pos;
    logic [VW-1:0]      pick_val;
    logic               out_load;

    assign in_accept = s_tvalid && s_tready;
    assign in_mode   = strmq_pkg::mode_t'(s_tuser);
    assign in_index  = s_tdata[strmq_pkg::S_IDX_LSB +: EIW];
    assign in_value  = s_tdata[strmq_pkg::S_VAL_LSB +: VW];
    assign in_left   = s_tdata[strmq_pkg::S_LEFT_LSB +: EIW];
    assign in_right  = s_tdata[strmq_pkg::S_RIGHT_LSB +: EIW];

    assign s_tready = (state_reg == strmq_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // length saturates at the store depth
    assign eff_len = (LEN_W'(array_length_reg) > LEN_W'(MAX_ELEMENTS))
                   ? LEN_W'(MAX_ELEMENTS) : LEN_W'(array_length_reg);
    assign idx_in_range = LEN_W'(in_index) < LEN_W'(MAX_ELEMENTS);
    assign q_err = (in_left > in_right) || (LEN_W'(in_right) >= eff_len);

    // build geometry for the current level
    assign span     = SPAN_W'(1) << lvl_reg;
    assign half     = span >> 1;
    assign row_p1   = SPAN_W'(row_reg) + SPAN_W'(1);
    assign row_half = IDX_W'(SPAN_W'(row_reg) + half);

    // query level: floor(log2(len)), clamped to the top level
    always_comb begin
        k_raw = '0;
        for (int j = 0; j < CW; j++) begin
            if (len_reg[j]) begin
                k_raw = KRAW_W'(j);
            end
        end
    end

    assign q_k      = (int'(k_raw) > TABLE_LEVELS - 1) ? LVL_W'(TABLE_LEVELS - 1)
                                                       : LVL_W'(k_raw);
    assign q_pow    = CW'(1) << q_k;
    assign q_start2 = EIW'(CW'(r_reg) + CW'(1) - q_pow);

    // build keeps the later block on equal values, query the first
    assign tie_first = (state_reg == strmq_pkg::ST_Q_OUT);
    assign cmp_lt    = $signed(elem_rdata_a) < $signed(elem_rdata_b);
    assign cmp_eq    = (elem_rdata_a == elem_rdata_b);
    assign pick_a    = cmp_lt || (tie_first && cmp_eq);
    assign pick_pos  = pick_a ? pos_a_reg : pos_b_reg;
    assign pick_val  = pick_a ? elem_rdata_a : elem_rdata_b;

    strmq_store #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .TABLE_LEVELS (TABLE_LEVELS)
    ) u_store (
        .aclk         (aclk),
        .ctl          (ctl),
        .elem_waddr   (elem_waddr),
        .elem_wdata   (in_value),
        .elem_raddr_a (elem_raddr_a),
        .elem_raddr_b (elem_raddr_b),
        .elem_rdata_a (elem_rdata_a),
        .elem_rdata_b (elem_rdata_b),
        .tab_wlvl     (tab_wlvl),
        .tab_wrow     (tab_wrow),
        .tab_wdata    (tab_wdata),
        .tab_rlvl     (tab_rlvl),
        .tab_rrow_a   (tab_rrow_a),
        .tab_rrow_b   (tab_rrow_b),
        .tab_rdata_a  (tab_rdata_a),
        .tab_rdata_b  (tab_rdata_b)
    );

    // sequencer: next state, memory strobes and payload updates
    always_comb begin
        state_next   = state_reg;
        lvl_next     = lvl_reg;
        row_next     = row_reg;
        l_next       = l_reg;
        r_next       = r_reg;
        len_next     = len_reg;
        err_next     = err_reg;
        k_next       = k_reg;
        start2_next  = start2_reg;
        pos_a_next   = pos_a_reg;
        pos_b_next   = pos_b_reg;
        ctl          = '0;
        elem_waddr   = IDX_W'(in_index);
        elem_raddr_a = pos_a_reg;
        elem_raddr_b = pos_b_reg;
        tab_wlvl     = lvl_reg - LVL_W'(1);
        tab_wrow     = row_reg;
        tab_wdata    = pick_pos;
        tab_rlvl     = '0;
        tab_rrow_a   = row_reg;
        tab_rrow_b   = row_half;
        out_load     = 1'b0;

        case (state_reg)
            strmq_pkg::ST_IDLE: begin
                if (in_accept) begin
                    case (in_mode)
                        strmq_pkg::MODE_WRITE: begin
                            ctl.elem_we = idx_in_range;
                        end
                        strmq_pkg::MODE_BUILD: begin
                            // a length below two leaves only the identity level
                            if (eff_len >= LEN_W'(2)) begin
                                lvl_next   = LVL_W'(1);
                                row_next   = '0;
                                state_next = strmq_pkg::ST_B_TAB;
                            end
                        end
                        strmq_pkg::MODE_QUERY: begin
                            l_next     = in_left;
                            r_next     = in_right;
                            len_next   = CW'(in_right) - CW'(in_left) + CW'(1);
                            err_next   = q_err;
                            state_next = q_err ? strmq_pkg::ST_Q_OUT : strmq_pkg::ST_Q_TAB;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // build: fetch the two half-block argmins of the level below
            strmq_pkg::ST_B_TAB: begin
                ctl.tab_re = (lvl_reg != LVL_W'(1));
                tab_rlvl   = lvl_reg - LVL_W'(2);
                tab_rrow_a = row_reg;
                tab_rrow_b = row_half;
                state_next = strmq_pkg::ST_B_VAL;
            end

            strmq_pkg::ST_B_VAL: begin
                pos_a_next   = (lvl_reg == LVL_W'(1)) ? row_reg  : tab_rdata_a;
                pos_b_next   = (lvl_reg == LVL_W'(1)) ? row_half : tab_rdata_b;
                ctl.elem_re  = 1'b1;
                elem_raddr_a = pos_a_next;
                elem_raddr_b = pos_b_next;
                state_next   = strmq_pkg::ST_B_CMP;
            end

            strmq_pkg::ST_B_CMP: begin
                ctl.tab_we = 1'b1;
                if ((row_p1 + span) <= SPAN_W'(eff_len)) begin
                    row_next   = IDX_W'(row_p1);
                    state_next = strmq_pkg::ST_B_TAB;
                end else if ((lvl_reg != LVL_W'(TABLE_LEVELS - 1))
                             && ((span << 1) <= SPAN_W'(eff_len))) begin
                    lvl_next   = lvl_reg + LVL_W'(1);
                    row_next   = '0;
                    state_next = strmq_pkg::ST_B_TAB;
                end else begin
                    state_next = strmq_pkg::ST_IDLE;
                end
            end

            // query: the block at left_index and the block ending at right_index
            strmq_pkg::ST_Q_TAB: begin
                ctl.tab_re  = (q_k != '0);
                tab_rlvl    = q_k - LVL_W'(1);
                tab_rrow_a  = IDX_W'(l_reg);
                tab_rrow_b  = IDX_W'(q_start2);
                k_next      = q_k;
                start2_next = q_start2;
                state_next  = strmq_pkg::ST_Q_VAL;
            end

            strmq_pkg::ST_Q_VAL: begin
                pos_a_next   = (k_reg == '0) ? IDX_W'(l_reg)      : tab_rdata_a;
                pos_b_next   = (k_reg == '0) ? IDX_W'(start2_reg) : tab_rdata_b;
                ctl.elem_re  = 1'b1;
                elem_raddr_a = pos_a_next;
                elem_raddr_b = pos_b_next;
                state_next   = strmq_pkg::ST_Q_OUT;
            end

            // element reads hold here until the output register frees up
            strmq_pkg::ST_Q_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = strmq_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = strmq_pkg::ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = '0;
            m_tuser_next  = strmq_pkg::M_TUSER_W'(err_reg);
            if (!err_reg) begin
                m_tdata_next[strmq_pkg::M_VAL_LSB +: VW] = pick_val;
                m_tdata_next[strmq_pkg::M_POS_LSB +: strmq_pkg::POS_OUT_W] =
                    strmq_pkg::POS_OUT_W'(pick_pos);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= strmq_pkg::ST_IDLE;
            m_tvalid_reg     <= 1'b0;
            array_length_reg <= CW'(1);
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                array_length_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        lvl_reg     <= lvl_next;
        row_reg     <= row_next;
        l_reg       <= l_next;
        r_reg       <= r_next;
        len_reg     <= len_next;
        err_reg     <= err_next;
        k_reg       <= k_next;
        start2_reg  <= start2_next;
        pos_a_reg   <= pos_a_next;
        pos_b_reg   <= pos_b_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    // a new result only comes out of the query compare step
    a_out_from_query: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == strmq_pkg::ST_Q_OUT))
        else $error("result item without a finished query");

    // an error result carries zero value and position
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("error result with nonzero payload");

    // every block the build combines lies inside the length
    a_build_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == strmq_pkg::ST_B_TAB) |->
            ((SPAN_W'(row_reg) + span) <= SPAN_W'(eff_len)))
        else $error("build block beyond array length");

    // second query block starts inside the range
    a_query_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == strmq_pkg::ST_Q_VAL) |->
            ((start2_reg >= l_reg) && (start2_reg <= r_reg)))
        else $error("query block outside the range");

endmodule

`default_nettype wire

// File: tb/sv/sparse_table_range_minimum_core_test.sv
// self-checking stream testbench for sparse_table_range_minimum_core
// needs strmq_pkg and the core rtl; checks every result item against an in-bench predictor
`timescale 1ns / 1ps

module sparse_table_range_minimum_core_test;
    import strmq_pkg::*;

    localparam int ELEMENT_SLOTS = DEF_MAX_ELEMENTS;
    localparam int LEVELS        = DEF_TABLE_LEVELS;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    // far above the slowest legal run
    localparam longint WATCHDOG_NS = 64'd24_000_000;

    // one input item, fields as they sit in the stream
    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic [ELEM_INDEX_W-1:0] right;
        logic [ELEM_INDEX_W-1:0] left;
        logic [VALUE_BITS-1:0]   val;
        logic [ELEM_INDEX_W-1:0] idx;
    } rmq_item_t;

    // one result item
    typedef struct packed {
        logic signed [VALUE_BITS-1:0] min_value;
        logic [POS_OUT_W-1:0]         min_position;
        logic                         range_error;
    } range_min_t;

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [LEN_CFG_W-1:0]   cfg_wr_data = '0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    // element_index, element_value, left_index, right_index, zero pad
    logic [S_TDATA_W-1:0]   s_tdata     = '0;
    // mode
    logic [S_TUSER_W-1:0]   s_tuser     = '0;
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    // min_value, min_position, zero pad
    logic [M_TDATA_W-1:0]   m_tdata;
    // range_error
    logic [M_TUSER_W-1:0]   m_tuser;

    sparse_table_range_minimum_core u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // predictor state: element values, argmin table, length register
    // ---------------------------------------------------------------
    logic signed [VALUE_BITS-1:0] elem_model   [ELEMENT_SLOTS];
    logic [POS_OUT_W-1:0]         argmin_model [LEVELS][ELEMENT_SLOTS];
    int unsigned                  span_model;

    range_min_t expected_minima [$];
    rmq_item_t  pending_items   [$];

    int error_count   = 0;
    int write_count   = 0;
    int build_count   = 0;
    int query_count   = 0;
    int flagged_count = 0;
    int noise_count   = 0;

    // idle percentages for the sender and the receiver side
    int unsigned s_idle_pct = 0;
    int unsigned m_idle_pct = 0;

    // length register saturates at the store size
    function automatic int unsigned covered_length();
        return (span_model > ELEMENT_SLOTS) ? ELEMENT_SLOTS : span_model;
    endfunction

    // level k, row i holds the argmin of the 2^k elements from i; ties keep the later one
    task automatic rebuild_argmin();
        int unsigned n;
        int unsigned half;
        logic [POS_OUT_W-1:0] a;
        logic [POS_OUT_W-1:0] b;
        n = covered_length();
        for (int unsigned i = 0; i < n; i++)
            argmin_model[0][i] = POS_OUT_W'(i);
        for (int unsigned lv = 1; lv < LEVELS && (1 << lv) <= n; lv++) begin
            half = 1 << (lv - 1);
            for (int unsigned i = 0; i + (1 << lv) <= n; i++) begin
                a = argmin_model[lv-1][i];
                b = argmin_model[lv-1][i+half];
                argmin_model[lv][i] = (elem_model[a] < elem_model[b]) ? a : b;
            end
        end
    endtask

    // two overlapping blocks at level floor(log2 span); ties keep the first block
    function automatic range_min_t predict_range_min(int unsigned l, int unsigned r);
        range_min_t res;
        int unsigned span;
        int unsigned lv;
        int unsigned start2;
        logic [POS_OUT_W-1:0] a;
        logic [POS_OUT_W-1:0] b;
        logic [POS_OUT_W-1:0] pick;
        res = '0;
        if (l > r || r >= covered_length()) begin
            res.range_error = 1'b1;
            return res;
        end
        span = r - l + 1;
        lv = 0;
        while (((span >> 1) >> lv) != 0)
            lv++;
        if (lv >= LEVELS)
            lv = LEVELS - 1;
        start2 = r + 1 - (1 << lv);
        a = argmin_model[lv][l];
        b = argmin_model[lv][start2];
        pick = (elem_model[a] <= elem_model[b]) ? a : b;
        res.min_value    = elem_model[pick];
        res.min_position = pick;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        error_count++;
    endtask

    // ---------------------------------------------------------------
    // driver: inputs change on the falling edge only
    // ---------------------------------------------------------------
    logic      s_taken = 1'b0;     // input item accepted at the last rising edge
    rmq_item_t next_item;

    always @(negedge aclk) begin
        if (!s_tvalid || s_taken) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= s_idle_pct) begin
                next_item = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= next_item.mode;
                // layout from the package: index, value, left, right from bit 0 up
                s_tdata  <= S_TDATA_W'({next_item.right, next_item.left,
                                        next_item.val, next_item.idx});
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= ($urandom_range(0, 99) >= m_idle_pct);
    end

    // ---------------------------------------------------------------
    // monitor: samples on the rising edge, feeds the predictor, checks results
    // ---------------------------------------------------------------
    range_min_t                   want;
    logic signed [VALUE_BITS-1:0] got_value;
    logic [POS_OUT_W-1:0]         got_position;
    logic                         got_error;

    always @(posedge aclk) begin
        if (!aresetn) begin
            span_model = 1;
            s_taken   <= 1'b0;
        end else begin
            s_taken <= s_tvalid && s_tready;
            if (cfg_wr_en)
                span_model = cfg_wr_data;

            if (m_tvalid && m_tready) begin
                got_value    = m_tdata[M_VAL_LSB +: VALUE_BITS];
                got_position = m_tdata[M_POS_LSB +: POS_OUT_W];
                got_error    = m_tuser[0];
                if (expected_minima.size() == 0) begin
                    report_mismatch($sformatf("unexpected result value %0d pos %0d err %b",
                                              got_value, got_position, got_error));
                end else begin
                    want = expected_minima.pop_front();
                    if (want.range_error)
                        flagged_count++;
                    if (got_value !== want.min_value)
                        report_mismatch($sformatf("min_value %0d, expected %0d",
                                                  got_value, want.min_value));
                    if (got_position !== want.min_position)
                        report_mismatch($sformatf("min_position %0d, expected %0d",
                                                  got_position, want.min_position));
                    if (got_error !== want.range_error)
                        report_mismatch($sformatf("range_error %b, expected %b",
                                                  got_error, want.range_error));
                end
            end

            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    MODE_WRITE: begin
                        elem_model[s_tdata[S_IDX_LSB +: ELEM_INDEX_W]] =
                            s_tdata[S_VAL_LSB +: VALUE_BITS];
                        write_count++;
                    end
                    MODE_BUILD: begin
                        rebuild_argmin();
                        build_count++;
                    end
                    MODE_QUERY: begin
                        expected_minima = {expected_minima, predict_range_min(
                            s_tdata[S_LEFT_LSB +: ELEM_INDEX_W],
                            s_tdata[S_RIGHT_LSB +: ELEM_INDEX_W])};
                        query_count++;
                    end
                    default: noise_count++;
                endcase
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus bookkeeping: what the core has been given so far, so that
    // no item ever makes it read an element or table row never written
    // ---------------------------------------------------------------
    bit          loaded [ELEMENT_SLOTS];
    int unsigned gen_len    = 1;   // length register as last written
    int unsigned built_span = 0;   // largest length any build has covered

    function automatic int unsigned gen_covered();
        return (gen_len > ELEMENT_SLOTS) ? ELEMENT_SLOTS : gen_len;
    endfunction

    // roughly the longest build at the current length, plus margin
    function automatic int unsigned settle_cycles();
        return 3 * gen_covered() * LEVELS + 40;
    endfunction

    // values lean toward small numbers so ties are frequent
    function automatic logic [VALUE_BITS-1:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return VALUE_BITS'(int'($urandom_range(0, 6)) - 3);
            4: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_item(input logic [MODE_W-1:0] mode,
                              input logic [ELEM_INDEX_W-1:0] idx,
                              input logic [VALUE_BITS-1:0] val,
                              input logic [ELEM_INDEX_W-1:0] left,
                              input logic [ELEM_INDEX_W-1:0] right);
        rmq_item_t it;
        it.mode  = mode;
        it.idx   = idx;
        it.val   = val;
        it.left  = left;
        it.right = right;
        pending_items = {pending_items, it};
    endtask

    // unused fields of every item carry random junk
    task automatic send_write(input int unsigned idx, input logic [VALUE_BITS-1:0] val);
        queue_item(MODE_WRITE, idx[ELEM_INDEX_W-1:0], val,
                   ELEM_INDEX_W'($urandom), ELEM_INDEX_W'($urandom));
        loaded[idx] = 1'b1;
    endtask

    // a build is always preceded by writes of whatever it would read unwritten
    task automatic send_build();
        for (int unsigned i = 0; i < gen_covered(); i++)
            if (!loaded[i])
                send_write(i, pick_value());
        queue_item(MODE_BUILD, ELEM_INDEX_W'($urandom), $urandom,
                   ELEM_INDEX_W'($urandom), ELEM_INDEX_W'($urandom));
        if (gen_covered() > built_span)
            built_span = gen_covered();
    endtask

    task automatic send_query(input int unsigned l, input int unsigned r);
        queue_item(MODE_QUERY, ELEM_INDEX_W'($urandom), $urandom,
                   l[ELEM_INDEX_W-1:0], r[ELEM_INDEX_W-1:0]);
    endtask

    // reversed range, or one that reaches past the length
    task automatic send_bad_query();
        int unsigned n;
        int unsigned l;
        int unsigned r;
        n = gen_covered();
        if (n < ELEMENT_SLOTS && $urandom_range(0, 1) == 1) begin
            r = $urandom_range(n, ELEMENT_SLOTS - 1);
            l = $urandom_range(0, ELEMENT_SLOTS - 1);
        end else begin
            r = $urandom_range(0, ELEMENT_SLOTS - 2);
            l = $urandom_range(r + 1, ELEMENT_SLOTS - 1);
        end
        send_query(l, r);
    endtask

    // in-range query that only touches table rows some build has written
    task automatic send_legal_query();
        int unsigned reach;
        int unsigned l;
        int unsigned r;
        reach = gen_covered();
        if (built_span < reach)
            reach = built_span;
        if (reach == 0) begin
            send_bad_query();
            return;
        end
        r = $urandom_range(0, reach - 1);
        case ($urandom_range(0, 4))
            0: l = r;
            1: l = 0;
            2: begin
                l = 0;
                r = reach - 1;
            end
            default: l = $urandom_range(0, r);
        endcase
        send_query(l, r);
    endtask

    task automatic random_phase(input int count, input int unsigned build_pct);
        int unsigned roll;
        int unsigned n;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(0, 99);
            n = gen_covered();
            if (roll < build_pct) begin
                send_build();
            end else if (roll < 50) begin
                send_legal_query();
            end else if (roll < 62) begin
                send_bad_query();
            end else if (roll < 95) begin
                // writes inside the length make the table stale
                if (n != 0 && $urandom_range(0, 1) == 1)
                    send_write($urandom_range(0, n - 1), pick_value());
                else
                    send_write($urandom_range(0, ELEMENT_SLOTS - 1), pick_value());
            end else begin
                queue_item(MODE_UNUSED, ELEM_INDEX_W'($urandom), $urandom,
                           ELEM_INDEX_W'($urandom), ELEM_INDEX_W'($urandom));
            end
        end
    endtask

    // everything sent, every result back, then time for a trailing build
    task automatic wait_quiet();
        while (pending_items.size() != 0 || s_tvalid || expected_minima.size() != 0)
            @(posedge aclk);
        repeat (settle_cycles()) @(posedge aclk);
    endtask

    task automatic set_array_length(input int unsigned len);
        wait_quiet();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len[LEN_CFG_W-1:0];
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        gen_len = len;
        @(posedge aclk);
    endtask

    task automatic set_idling(input int unsigned s_pct, input int unsigned m_pct);
        s_idle_pct = s_pct;
        m_idle_pct = m_pct;
    endtask

    // ---------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------
    initial begin
        logic [VALUE_BITS-1:0] seed_vals [8];
        seed_vals = '{32'd5, -32'sd3, 32'd7, -32'sd3,
                      32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'd0};

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        set_idling(14, 80);

        // length straight out of reset is one element
        send_query(1, 0);
        send_write(0, 32'h8000_0000);
        send_build();
        send_query(0, 0);
        send_query(0, 1);

        // eight elements with equal values for both tie rules, plus the extremes
        set_array_length(8);
        for (int unsigned i = 0; i < 8; i++)
            send_write(i, seed_vals[i]);
        send_write(ELEMENT_SLOTS - 1, 32'h7FFF_FFFF);
        send_build();
        send_query(0, 7);
        send_query(1, 3);
        send_query(7, 7);
        send_query(2, 6);
        send_query(4, 7);
        send_query(0, 8);
        // overwrite after the build: the query works from the stale table
        send_write(5, 32'd100);
        send_query(0, 7);

        // three idle patterns, small random lengths; the last length of each
        // pattern keeps whatever table was built before it
        for (int unsigned pat = 0; pat < 3; pat++) begin
            case (pat)
                0:       set_idling(14, 80);
                1:       set_idling(80, 14);
                default: set_idling(0, 0);
            endcase
            for (int unsigned sub = 0; sub < 3; sub++) begin
                set_array_length((pat == 0 && sub == 0) ? 1 : $urandom_range(2, 48));
                if (sub != 2)
                    send_build();
                random_phase(20, 6);
            end
        end

        // largest sizes: saturating length, exact full length on the old table, zero
        set_array_length(2047);
        send_build();
        random_phase(40, 1);
        set_array_length(ELEMENT_SLOTS);
        random_phase(20, 0);
        set_array_length(0);
        random_phase(10, 5);

        wait_quiet();
        if (expected_minima.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_minima.size()));

        $display("run covered %0d element writes, %0d table builds, %0d range queries",
                 write_count, build_count, query_count);
        $display("of those %0d were flagged out of range; %0d unused-mode items sent",
                 flagged_count, noise_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #(WATCHDOG_NS);
        $display("timeout with %0d items pending, %0d results outstanding",
                 pending_items.size(), expected_minima.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/strmq_pkg.sv
rtl/core/strmq_store.sv
rtl/core/sparse_table_range_minimum_core.sv
tb/sv/sparse_table_range_minimum_core_test.sv
